// ===== hw/rtl/chrl_pkg.sv =====
package chrl_pkg;

    localparam int RING_DEPTH_DEF   = 2048;
    localparam int SERVER_COUNT_DEF = 16;
    localparam int POINT_W          = 32;
    localparam int TAG_W            = 4;
    localparam int INDEX_W          = 11;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [POINT_W-1:0] ring_point;
        logic [TAG_W-1:0]   server_tag;
        logic [POINT_W-1:0] key_hash;
    } ring_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]   chosen_server;
        logic [INDEX_W-1:0] ring_index;
        logic               ring_empty;
        logic               ring_full;
    } ring_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_LOOK_RD,
        ST_LOOK_DONE,
        ST_OUT
    } ring_state_t;

endpackage

// ===== hw/rtl/chrl_ram.sv =====
module chrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/chrl_ctrl.sv =====
module chrl_ctrl import chrl_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int AW = $clog2(RING_DEPTH),
    localparam int CW = $clog2(RING_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ring_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ring_out_t           m_data,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [POINT_W+TAG_W-1:0] wdata,
    output logic [AW-1:0]       raddr,
    input  logic [POINT_W+TAG_W-1:0] rdata
);
    ring_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [1:0] act_reg, act_next;
    logic [POINT_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    ring_out_t res_reg, res_next;
    logic [CW-1:0] mid;
    logic [POINT_W-1:0] rd_point;
    logic go_right;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_point = rdata[POINT_W+TAG_W-1:TAG_W];
    // insert wants upper bound, lookup lower bound
    assign go_right = (act_reg == ACT_INSERT) ? (rd_point <= key_reg) : (rd_point < key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        act_reg <= act_next;
        key_reg <= key_next;
        tag_reg <= tag_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        ptr_next = ptr_reg;
        act_next = act_reg;
        key_next = key_reg;
        tag_next = tag_reg;
        res_next = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next = s_data.action;
                    tag_next = s_data.server_tag;
                    key_next = (s_data.action == ACT_INSERT) ? s_data.ring_point
                                                             : s_data.key_hash;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    res_next = '0;
                    state_next = ST_OUT;
                    unique case (action_t'(s_data.action))
                        ACT_CLEAR: count_next = '0;
                        ACT_INSERT: begin
                            if (count_reg == CW'(RING_DEPTH)) begin
                                res_next.ring_full = 1'b1;
                            end else begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_next.ring_empty = 1'b1;
                            end else begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRCH_RD: begin
                if (lo_reg == hi_reg) begin
                    if (act_reg == ACT_INSERT) begin
                        ptr_next = count_reg;
                        state_next = ST_SHIFT_RD;
                    end else begin
                        ptr_next = (lo_reg >= count_reg) ? '0 : lo_reg;
                        state_next = ST_LOOK_RD;
                    end
                end else begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (go_right) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_SRCH_RD;
            end
            ST_SHIFT_RD: begin
                // walk from the tail down, moving each entry up one slot
                if (ptr_reg == lo_reg) begin
                    count_next = count_reg + 1'b1;
                    res_next.ring_index = INDEX_W'(lo_reg);
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                ptr_next = ptr_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_LOOK_RD: state_next = ST_LOOK_DONE;
            ST_LOOK_DONE: begin
                res_next.chosen_server = rdata[TAG_W-1:0];
                res_next.ring_index = INDEX_W'(ptr_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        m_data  = res_reg;
        we      = 1'b0;
        waddr   = ptr_reg[AW-1:0];
        wdata   = rdata;
        raddr   = mid[AW-1:0];
        unique case (state_reg)
            ST_SHIFT_RD: begin
                raddr = AW'(ptr_reg - 1'b1);
                if (ptr_reg == lo_reg) begin
                    we    = 1'b1;
                    wdata = {key_reg, tag_reg};
                end
            end
            ST_SHIFT_WR: we = 1'b1;
            ST_LOOK_RD:  raddr = ptr_reg[AW-1:0];
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/consistent_hash_ring_lookup_unit.sv =====
// Sorted ring of up to RING_DEPTH (point, server) entries in one RAM. Lookup is a
// binary search with each probe bound by the single registered RAM read port.
// Insert searches the same way, then moves each later entry up one slot.
// Clear, unused actions, a refused insert and a lookup on an empty ring go from
// idle straight to the result without a search.
// One word is processed at a time; a result is held until taken.
module consistent_hash_ring_lookup_unit import chrl_pkg::*; #(
    parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ring_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ring_out_t m_data
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int EW = POINT_W + TAG_W;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    chrl_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    chrl_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import chrl_pkg::*;

    localparam int DEPTH    = RING_DEPTH_DEF;
    localparam int WD_LIMIT = 40000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ring_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ring_out_t m_data;

    consistent_hash_ring_lookup_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor's copy of the ring
    logic [POINT_W-1:0] ring_pts [DEPTH];
    logic [TAG_W-1:0]   ring_tags[DEPTH];
    int                 ring_cnt;

    ring_out_t route_q[$];
    int        err_cnt;
    int        idle_cnt;
    bit        no_idle;
    bit        timed_out;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic ring_out_t route_word(input ring_in_t w);
        ring_out_t r;
        int lo, hi, mid;
        r = '0;
        case (action_t'(w.action))
            ACT_CLEAR: ring_cnt = 0;
            ACT_INSERT: begin
                if (ring_cnt >= DEPTH) begin
                    r.ring_full = 1'b1;
                end else begin
                    lo = 0; hi = ring_cnt;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (ring_pts[mid] <= w.ring_point) lo = mid + 1;
                        else hi = mid;
                    end
                    for (int i = ring_cnt; i > lo; i--) begin
                        ring_pts[i]  = ring_pts[i-1];
                        ring_tags[i] = ring_tags[i-1];
                    end
                    ring_pts[lo]  = w.ring_point;
                    ring_tags[lo] = w.server_tag;
                    ring_cnt++;
                    r.ring_index = lo[INDEX_W-1:0];
                end
            end
            ACT_LOOKUP: begin
                if (ring_cnt == 0) begin
                    r.ring_empty = 1'b1;
                end else begin
                    lo = 0; hi = ring_cnt;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (ring_pts[mid] < w.key_hash) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo >= ring_cnt) lo = 0;
                    r.ring_index    = lo[INDEX_W-1:0];
                    r.chosen_server = ring_tags[lo];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic ring_in_t mk(input action_t a, input logic [31:0] p,
                                    input logic [3:0] t, input logic [31:0] k);
        ring_in_t w;
        w.action = a; w.ring_point = p; w.server_tag = t; w.key_hash = k;
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_word(input ring_in_t w, input bit has_want, input ring_out_t want);
        ring_out_t p;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        p = route_word(w);
        if (has_want && p != want)
            report("directed row", 32'(p), 32'(want));
        route_q.push_back(p);
        @(negedge aclk);
    endtask

    // receive side
    always @(posedge aclk) begin
        ring_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (route_q.size() == 0) begin
                report("unexpected word", 32'(m_data), 0);
            end else begin
                e = route_q.pop_front();
                if (m_data.chosen_server != e.chosen_server)
                    report("chosen_server", 32'(m_data.chosen_server), 32'(e.chosen_server));
                if (m_data.ring_index != e.ring_index)
                    report("ring_index", 32'(m_data.ring_index), 32'(e.ring_index));
                if (m_data.ring_empty != e.ring_empty)
                    report("ring_empty", 32'(m_data.ring_empty), 32'(e.ring_empty));
                if (m_data.ring_full != e.ring_full)
                    report("ring_full", 32'(m_data.ring_full), 32'(e.ring_full));
            end
        end
    end

    // output stall bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (no_idle || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("** consistent_hash_ring_lookup_unit: FAILED **");
            $finish;
        end
    end

    typedef struct {
        ring_in_t  w;
        bit        has_want;
        ring_out_t want;
    } dir_row_t;

    dir_row_t dir_tab[$];

    task automatic row(input ring_in_t w, input bit hw, input ring_out_t want);
        dir_row_t d;
        d.w = w; d.has_want = hw; d.want = want;
        dir_tab.push_back(d);
    endtask

    task automatic fill_full();
        // fill ring to capacity with sorted-ascending points so shifts stay short
        for (int i = 0; i < DEPTH; i++)
            send_word(mk(ACT_INSERT, i * 32'd2000000, 4'($urandom), $urandom), 0, '0);
    endtask

    initial begin
        ring_in_t  w;
        ring_out_t z;
        int        n;
        err_cnt = 0; ring_cnt = 0; no_idle = 0; timed_out = 0;
        z = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        row(mk(ACT_LOOKUP, 0, 0, 32'h0), 1, '{4'd0, 11'd0, 1'b1, 1'b0});
        row(mk(ACT_NONE, 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF), 1, z);
        row(mk(ACT_INSERT, 32'h0, 4'hF, 32'hFFFFFFFF), 1, z);
        row(mk(ACT_INSERT, 32'hFFFFFFFF, 4'h0, 0), 1, '{4'd0, 11'd1, 1'b0, 1'b0});
        row(mk(ACT_INSERT, 32'h80000000, 4'hA, 0), 1, '{4'd0, 11'd1, 1'b0, 1'b0});
        row(mk(ACT_INSERT, 32'h80000000, 4'h5, 0), 1, '{4'd0, 11'd2, 1'b0, 1'b0});
        row(mk(ACT_LOOKUP, 0, 0, 32'h80000000), 1, '{4'hA, 11'd1, 1'b0, 1'b0});
        row(mk(ACT_LOOKUP, 0, 0, 32'h0), 1, '{4'hF, 11'd0, 1'b0, 1'b0});
        row(mk(ACT_LOOKUP, 0, 0, 32'hFFFFFFFF), 0, z);
        row(mk(ACT_LOOKUP, 0, 0, 32'h80000001), 0, z);
        row(mk(ACT_CLEAR, 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF), 1, z);
        row(mk(ACT_INSERT, 32'h12345678, 4'h3, 0), 1, z);
        row(mk(ACT_LOOKUP, 0, 0, 32'h12345679), 1, '{4'h3, 11'd0, 1'b0, 1'b0});
        row(mk(ACT_NONE, 0, 0, 0), 1, z);
        row(mk(ACT_LOOKUP, 32'hFFFFFFFF, 4'hF, 32'h00000001), 0, z);
        row(mk(ACT_CLEAR, 0, 0, 0), 1, z);
        foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].has_want, dir_tab[i].want);

        // full ring: refuse, then lookups and wrap
        fill_full();
        send_word(mk(ACT_INSERT, $urandom, 4'($urandom), 0), 1, '{4'd0, 11'd0, 1'b0, 1'b1});
        for (int i = 0; i < 12; i++) send_word(mk(ACT_LOOKUP, 0, 0, $urandom), 0, z);
        send_word(mk(ACT_LOOKUP, 0, 0, 32'hFFFFFFFF), 0, z);
        send_word(mk(ACT_CLEAR, 0, 0, 0), 1, z);

        // random: mostly small rings with lookups, inserts, occasional clear and noise
        n = 0;
        while (n < 850) begin
            if (n > 700) no_idle = 1;
            case ($urandom_range(0, 19))
                0:       w = mk(ACT_CLEAR, $urandom, 4'($urandom), $urandom);
                1:       w = mk(ACT_NONE, $urandom, 4'($urandom), $urandom);
                2, 3, 4, 5, 6, 7:
                    w = mk(ACT_INSERT, ($urandom_range(0, 3) == 0) ?
                           {3'($urandom_range(0, 7)), 29'd0} : $urandom,
                           4'($urandom), $urandom);
                default: begin
                    w = mk(ACT_LOOKUP, $urandom, 4'($urandom), $urandom);
                    if ($urandom_range(0, 3) == 0 && ring_cnt > 0)
                        w.key_hash = ring_pts[$urandom_range(0, ring_cnt - 1)] +
                                     $urandom_range(0, 2) - 1;
                end
            endcase
            if (ring_cnt > 200 && w.action == ACT_INSERT) w.action = ACT_CLEAR;
            send_word(w, 0, z);
            n++;
        end
        s_valid <= 1'b0;

        while (route_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** consistent_hash_ring_lookup_unit: PASSED **");
        end else begin
            $display("** consistent_hash_ring_lookup_unit: FAILED **");
        end
        $finish;
    end

endmodule
